// File: sv/plhr_pkg.sv
// plhr_pkg: widths, constants, codes and the controller/datapath interface types
// for the peak limiter with hold and release; depends on nothing
`default_nettype none

package plhr_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int GAIN_WIDTH   = 24;
    localparam int COEFF_WIDTH  = 24;
    localparam int CEIL_WIDTH   = 24;
    localparam int HOLD_WIDTH   = 20;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 24;

    localparam logic [GAIN_WIDTH-1:0] UNITY_GAIN = GAIN_WIDTH'(8388608);

    localparam logic [CEIL_WIDTH-1:0]  CEIL_RESET  = CEIL_WIDTH'(8388608);
    localparam logic [COEFF_WIDTH-1:0] COEFF_RESET = COEFF_WIDTH'(16609444);
    localparam logic [HOLD_WIDTH-1:0]  HOLD_RESET  = '0;

    // multiplier: wide operand times a gain-wide operand, two half slices
    localparam int MUL_A_WIDTH = (SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH;
    localparam int HALF_WIDTH  = GAIN_WIDTH / 2;
    localparam int PP_WIDTH    = MUL_A_WIDTH + HALF_WIDTH;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + GAIN_WIDTH;

    // limit = ceiling * 2^(SAMPLE_WIDTH-1)
    localparam int LIMIT_WIDTH   = CEIL_WIDTH + SAMPLE_WIDTH - 1;
    localparam int DIV_HI_WIDTH  = LIMIT_WIDTH - GAIN_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(GAIN_WIDTH);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CEILING = CFG_INDEX_WIDTH'(0),
        CFG_RELEASE = CFG_INDEX_WIDTH'(1),
        CFG_HOLD    = CFG_INDEX_WIDTH'(2)
    } cfg_index_t;

    typedef enum logic {
        MUL_REL = 1'b0,
        MUL_CMP = 1'b1
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     hold_dec;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     rel_update;
        logic     div_start;
        logic     div_update;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hold_nz;
        logic gain_below;
        logic mul_done;
        logic div_done;
        logic over;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/plhr_mul.sv
// plhr_mul: two-step multiplier, one half-width partial product per cycle
// depends on plhr_pkg
`default_nettype none

module plhr_mul
    import plhr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [MUL_A_WIDTH-1:0] a,
    input  wire logic [GAIN_WIDTH-1:0]  b,
    output logic                        done,
    output logic [PROD_WIDTH-1:0]       prod
);

    logic                   busy_reg, busy_next;
    logic                   half_reg, half_next;
    logic                   done_reg, done_next;
    logic [MUL_A_WIDTH-1:0] a_reg;
    logic [GAIN_WIDTH-1:0]  b_reg;
    logic [PROD_WIDTH-1:0]  prod_reg, prod_next;
    logic [HALF_WIDTH-1:0]  b_slice;
    logic [PP_WIDTH-1:0]    pp;

    always_comb
    begin
        b_slice = half_reg ? b_reg[GAIN_WIDTH-1:HALF_WIDTH] : b_reg[HALF_WIDTH-1:0];
        pp      = PP_WIDTH'(a_reg) * PP_WIDTH'(b_slice);
        busy_next = busy_reg;
        half_next = half_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        if (start)
        begin
            busy_next = 1'b1;
            half_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!half_reg)
            begin
                prod_next = PROD_WIDTH'(pp);
                half_next = 1'b1;
            end
            else
            begin
                prod_next = prod_reg + (PROD_WIDTH'(pp) << HALF_WIDTH);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            half_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            half_reg <= half_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

// File: sv/plhr_div.sv
// plhr_div: restoring divider, one quotient bit per cycle, gain-wide quotient
// depends on plhr_pkg
`default_nettype none

module plhr_div
    import plhr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [LIMIT_WIDTH-1:0]  dividend,
    input  wire logic [SAMPLE_WIDTH-1:0] divisor,
    output logic                         done,
    output logic [GAIN_WIDTH-1:0]        quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_WIDTH-1:0]  rem_reg, rem_next;
    logic [GAIN_WIDTH-1:0]    lo_reg, lo_next;
    logic [SAMPLE_WIDTH-1:0]  dsr_reg;
    logic [SAMPLE_WIDTH-1:0]  trial;
    logic [SAMPLE_WIDTH-1:0]  init_rem;
    logic                     ge;

    // top bits of the dividend start below the divisor, so the quotient fits
    assign init_rem = {1'b0, dividend[LIMIT_WIDTH-1:GAIN_WIDTH]};

    always_comb
    begin
        trial = {rem_reg[SAMPLE_WIDTH-2:0], lo_reg[GAIN_WIDTH-1]};
        ge    = (trial >= dsr_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = init_rem;
            lo_next   = dividend[GAIN_WIDTH-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - dsr_reg) : trial;
            lo_next  = {lo_reg[GAIN_WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_WIDTH'(GAIN_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (init_rem < divisor))
        else $error("divider started with a quotient that overflows the gain");

endmodule

`default_nettype wire

// File: sv/plhr_datapath.sv
// plhr_datapath: configuration registers, gain and hold state, sample latch,
// shared multiplier and divider, output word register; depends on plhr_pkg,
// plhr_mul and plhr_div
`default_nettype none

module plhr_datapath
    import plhr_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]      cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic                           block_end,
    input  wire ctrl_cmd_t                      cmd,
    output dp_status_t                          status,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    output logic [GAIN_WIDTH-1:0]               gain_out,
    output logic                                block_end_out
);

    logic [CEIL_WIDTH-1:0]   ceiling_reg;
    logic [COEFF_WIDTH-1:0]  coeff_reg;
    logic [HOLD_WIDTH-1:0]   hold_length_reg;
    logic [GAIN_WIDTH-1:0]   gain_reg, gain_next;
    logic [HOLD_WIDTH-1:0]   hold_reg, hold_next;
    logic [SAMPLE_WIDTH-1:0] mag_reg;
    logic                    neg_reg;
    logic                    blk_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic [GAIN_WIDTH-1:0]   gain_out_reg;
    logic                    block_end_out_reg;

    logic [SAMPLE_WIDTH-1:0] raw;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [GAIN_WIDTH-1:0]   deficit;
    logic [LIMIT_WIDTH-1:0]  limit;
    logic [MUL_A_WIDTH-1:0]  mul_a;
    logic [GAIN_WIDTH-1:0]   mul_b;
    logic [PROD_WIDTH-1:0]   prod;
    logic                    mul_done;
    logic [GAIN_WIDTH-1:0]   quotient;
    logic                    div_done;
    logic [GAIN_WIDTH-1:0]   rel_gain;
    logic [SAMPLE_WIDTH-1:0] scaled;
    logic [SAMPLE_WIDTH-1:0] result;
    logic                    out_free;

    assign raw     = $unsigned(sample_in);
    assign mag     = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign deficit = UNITY_GAIN - gain_reg;
    assign limit   = {ceiling_reg, {(SAMPLE_WIDTH-1){1'b0}}};

    assign mul_a = (cmd.mul_sel == MUL_REL) ? MUL_A_WIDTH'(deficit) : MUL_A_WIDTH'(mag_reg);
    assign mul_b = (cmd.mul_sel == MUL_REL) ? coeff_reg : gain_reg;

    plhr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    plhr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (limit),
        .divisor  (mag_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // unity minus floor(deficit * coeff / 2^24)
    assign rel_gain = GAIN_WIDTH'({1'b0, UNITY_GAIN} - {1'b0, prod[GAIN_WIDTH +: GAIN_WIDTH]});
    assign scaled   = prod[GAIN_WIDTH-1 +: SAMPLE_WIDTH];
    assign result   = neg_reg ? (~scaled + 1'b1) : scaled;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.hold_nz    = (hold_reg != '0);
        status.gain_below = (gain_reg < UNITY_GAIN);
        status.mul_done   = mul_done;
        status.div_done   = div_done;
        status.over       = (prod > PROD_WIDTH'(limit));
        status.out_free   = out_free;
    end

    always_comb
    begin
        gain_next = gain_reg;
        hold_next = hold_reg;
        if (cmd.hold_dec)
        begin
            hold_next = hold_reg - 1'b1;
        end
        if (cmd.rel_update)
        begin
            gain_next = rel_gain;
        end
        if (cmd.div_update)
        begin
            gain_next = quotient;
            hold_next = hold_length_reg;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg     <= CEIL_RESET;
            coeff_reg       <= COEFF_RESET;
            hold_length_reg <= HOLD_RESET;
            gain_reg        <= UNITY_GAIN;
            hold_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CEILING: ceiling_reg     <= cfg_data[CEIL_WIDTH-1:0];
                    CFG_RELEASE: coeff_reg       <= cfg_data[COEFF_WIDTH-1:0];
                    CFG_HOLD:    hold_length_reg <= cfg_data[HOLD_WIDTH-1:0];
                    default:     ;
                endcase
            end
            gain_reg      <= gain_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag;
            neg_reg <= raw[SAMPLE_WIDTH-1];
            blk_reg <= block_end;
        end
        if (cmd.out_load)
        begin
            sample_out_reg    <= result;
            gain_out_reg      <= gain_reg;
            block_end_out_reg <= blk_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = $signed(sample_out_reg);
    assign gain_out      = gain_out_reg;
    assign block_end_out = block_end_out_reg;

    a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY_GAIN)
        else $error("gain above unity");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output word overwritten before it was taken");

    a_div_needed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> status.over)
        else $error("division started without a reduction");

endmodule

`default_nettype wire

// File: sv/plhr_ctrl.sv
// plhr_ctrl: per-sample sequencer: hold or release, ceiling check, division,
// final product and output handoff; depends on plhr_pkg
`default_nettype none

module plhr_ctrl
    import plhr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_HOLD = 10'b00_0000_0010,
        S_REL  = 10'b00_0000_0100,
        S_CMP  = 10'b00_0000_1000,
        S_CMPW = 10'b00_0001_0000,
        S_DEC  = 10'b00_0010_0000,
        S_DIV  = 10'b00_0100_0000,
        S_FIN  = 10'b00_1000_0000,
        S_FINW = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_CMP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (status.hold_nz)
                begin
                    cmd.hold_dec = 1'b1;
                    state_next   = S_CMP;
                end
                else if (status.gain_below)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_REL;
                    state_next    = S_REL;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_REL:
            begin
                if (status.mul_done)
                begin
                    cmd.rel_update = 1'b1;
                    state_next     = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_CMPW;
            end
            S_CMPW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                // product of the check is reused as the output when no reduction
                if (status.over)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_update = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_FINW;
            end
            S_FINW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_HOLD))
        else $error("accepted word not followed by hold step");

endmodule

`default_nettype wire

// File: sv/peak_limiter_hold_release_core.sv
// peak_limiter_hold_release_core: top level of the peak limiter with hold and
// release; depends on plhr_pkg, plhr_ctrl and plhr_datapath
//
// Input channel (in_valid/in_ready) takes one word: a signed sample and a
// block_end flag. Output channel (out_valid/out_ready) returns one word per
// input: the limited sample, the gain applied and the copied block_end flag.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// ceiling (0), release coefficient (1) and hold length (2); other indexes are
// ignored. Write it only while the block is idle; cfg_ready is always high.
// Without release or reduction, an accepted word passes the hold step, the
// ceiling check product and the decision on its way to the output; a release
// adds a multiplier pass, and a new reduction runs the bit-serial divider and
// a second pass of the multiplier. One word is in flight at a time; in_ready
// returns in the cycle after the result moves into the output register. A
// stalled receiver holds the output word and blocks only the next result
// handoff, and with it the input.
// Reset is asynchronous: gain returns to unity, hold count to zero, the
// registers to their defaults and the output register is emptied.
`default_nettype none

module peak_limiter_hold_release_core
    import plhr_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic                           block_end,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    output logic [GAIN_WIDTH-1:0]               gain_out,
    output logic                                block_end_out,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    plhr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    plhr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_in     (sample_in),
        .block_end     (block_end),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .gain_out      (gain_out),
        .block_end_out (block_end_out)
    );

endmodule

`default_nettype wire
